// ===== hdl/keyed_flag_table_assert.svh =====
// Assertion macros shared by the keyed flag table RTL.
`ifndef KEYED_FLAG_TABLE_ASSERT_SVH
`define KEYED_FLAG_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kft_pkg.sv =====
// Package with the field widths and operation and status codes of the keyed flag table.
package kft_pkg;

   localparam int KEY_W    = 16;
   localparam int CAP_W    = 5;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [CAP_W-1:0]    cap_type;

   // Operation codes.
   localparam op_type OP_INSERT  = 2'd0;
   localparam op_type OP_REMOVE  = 2'd1;
   localparam op_type OP_SETMARK = 2'd2;
   localparam op_type OP_QUERY   = 2'd3;

   // Status codes.
   localparam status_type STS_OK      = 2'd0;
   localparam status_type STS_FULL    = 2'd1;
   localparam status_type STS_DUP     = 2'd2;
   localparam status_type STS_MISSING = 2'd3;

   // Reset value of the capacity register.
   localparam cap_type CAP_RESET = 5'd16;

endpackage

// ===== hdl/keyed_flag_table.sv =====
// Keyed flag table: a small table of unique keys with a one-bit mark each.
//
// Usage: present an item on req_op, req_key and req_mark_value with start
// high; it is taken at a clock edge where busy is low. Each item produces
// exactly one result on rsp_status and rsp_mark, shown for one cycle with
// rsp_strobe high. The receiver cannot stall; results must be taken when shown.
// The user writes the capacity register (csr_we, csr_wdata) only while idle; the block
// does not enforce this.
// Entries live in one synchronous memory (one read, one write port, read data
// registered). A lookup streams one entry per cycle through the read port: a miss
// reads all occupied entries and a hit in slot i stops after slot i; a remove then
// reads the last entry (ST_RM_READ) and moves it into the freed slot (ST_RM_WRITE).
// The result is shown in the first cycle with busy low, and the next item can be
// taken at the edge that ends that cycle. An insert into a full table answers in
// the cycle after it is taken, without raising busy.
//
// Reset clears the entry count and sets capacity to 16; the memory itself is
// not cleared, since only occupied entries are ever read.
module keyed_flag_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  kft_pkg::op_type       req_op,
   input  kft_pkg::key_type      req_key,
   input  logic                  req_mark_value,
   output logic                  rsp_strobe,
   output kft_pkg::status_type   rsp_status,
   output logic                  rsp_mark,
   input  logic                  csr_we,
   input  kft_pkg::cap_type      csr_wdata
);
   import kft_pkg::*;

   `include "keyed_flag_table_assert.svh"

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int ENT_W = KEY_W + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RM_READ,
      ST_RM_WRITE
   } state_type;

   state_type        state_ff;
   op_type           op_ff;
   key_type          key_ff;
   logic             mv_ff;
   cap_type          capacity_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             rsp_strobe_ff;
   status_type       rsp_status_ff;
   logic             rsp_mark_ff;

   // Entry memory: mark in the top bit, key below it.
   logic [ENT_W-1:0] mem [MAX_ENTRIES];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   logic accept;
   logic full;
   logic issue;
   logic hit;
   logic miss;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Full when the count reaches the capacity or the built depth.
   assign full = (CMP_W'(count_ff) >= CMP_W'(capacity_ff)) || (count_ff == MAX_CNT);

   // Search pipeline: issue one read per cycle, compare the entry read last cycle.
   assign issue = (scan_ff < count_ff);
   assign hit   = chk_vld_ff && (rd_data_ff[KEY_W-1:0] == key_ff);
   assign miss  = !hit && !chk_vld_ff && !issue;

   // Memory port control.
   always_comb begin
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = rd_data_ff;
      unique case (state_ff)
         ST_SEARCH: begin
            if (hit && op_ff == OP_SETMARK) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff;
               wr_data = {mv_ff, key_ff};
            end else if (miss && op_ff == OP_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[IDX_W-1:0];
               wr_data = {1'b0, key_ff};
            end
         end
         ST_RM_READ: begin
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
         end
         ST_RM_WRITE: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Synchronous memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Sequencer with registered result outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff      <= req_op;
                  key_ff     <= req_key;
                  mv_ff      <= req_mark_value;
                  scan_ff    <= '0;
                  chk_vld_ff <= 1'b0;
                  if (req_op == OP_INSERT && full) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= STS_FULL;
                     rsp_mark_ff   <= 1'b0;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (hit) begin
                  slot_ff       <= chk_idx_ff;
                  rsp_mark_ff   <= 1'b0;
                  rsp_status_ff <= STS_OK;
                  case (op_ff)
                     OP_INSERT: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_status_ff <= STS_DUP;
                        state_ff      <= ST_IDLE;
                     end
                     OP_REMOVE: begin
                        state_ff <= ST_RM_READ;
                     end
                     OP_SETMARK: begin
                        rsp_strobe_ff <= 1'b1;
                        state_ff      <= ST_IDLE;
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_mark_ff   <= rd_data_ff[KEY_W];
                        state_ff      <= ST_IDLE;
                     end
                  endcase
               end else if (miss) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_mark_ff   <= 1'b0;
                  state_ff      <= ST_IDLE;
                  if (op_ff == OP_INSERT) begin
                     rsp_status_ff <= STS_OK;
                     count_ff      <= count_ff + CNT_W'(1);
                  end else begin
                     rsp_status_ff <= STS_MISSING;
                  end
               end else begin
                  chk_vld_ff <= issue;
                  chk_idx_ff <= scan_ff[IDX_W-1:0];
                  if (issue) begin
                     scan_ff <= scan_ff + CNT_W'(1);
                  end
               end
            end
            ST_RM_READ: begin
               state_ff <= ST_RM_WRITE;
            end
            ST_RM_WRITE: begin
               // The last entry is written into the freed slot at this edge.
               count_ff      <= count_ff - CNT_W'(1);
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= STS_OK;
               rsp_mark_ff   <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_mark   = rsp_mark_ff;

   // The entry count never passes the built depth.
   `KFT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT,
                    "entry count beyond depth")
   // A result is only shown once the sequencer is back in idle.
   `KFT_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE,
                    "result shown while busy")
   // An insert into a full table answers full in the next cycle.
   `KFT_ASSERT_NEXT(a_full_fast, clock, reset, accept && req_op == OP_INSERT && full,
                    rsp_strobe_ff && rsp_status_ff == STS_FULL, "full insert not rejected")
   // A successful insert grows the table by one entry.
   `KFT_ASSERT_SAME(a_insert_count, clock, reset,
                    rsp_strobe_ff && op_ff == OP_INSERT && rsp_status_ff == STS_OK
                    && !$past(rsp_strobe_ff && state_ff == ST_IDLE && !start),
                    count_ff == $past(count_ff) + CNT_W'(1), "insert did not count")

endmodule
